/* rtl/ipid_pkg.sv */
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types and constants of the incremental PID controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int DEF_GAIN_WIDTH = 16;
  localparam int DEF_OUT_WIDTH  = 32;

  localparam int IN_W      = 16;  // measured / target
  localparam int ERR_W     = 17;  // target - measured
  localparam int DIFF1_W   = 18;  // e - e1
  localparam int DIFF2_W   = 19;  // e - 2*e1 + e2
  localparam int LIMIT_W   = 31;
  localparam int SHIFT_W   = 4;
  localparam int DECIM_W   = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_OUT_LIMIT   = 3'd3,
    CFG_INT_SHIFT   = 3'd4,
    CFG_DECIM_RLD   = 3'd5,
    CFG_ZERO_CLEAR  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

endpackage

/* rtl/incremental_pid_controller.sv */
// ----------------------------------------------------------------------------
// incremental_pid_controller
// Velocity-form PID with decimation, zero-target clear and output clamp.
//
// Input stream: s_axis_tdata = {target, measured}, one sample per item.
// Output stream: one item per sample, m_axis_tdata = drive (clamped
// accumulator), m_axis_tuser = updated (1 when this sample ran the PID).
// The user sets gains, limit, integral shift, decimation reload and clear mode
// through the cfg write port while no item is in flight (block does not check).
// Pipeline: input register, product register (three parallel multiplies
// on the error terms), then sum and clamp into the output register.
// m_axis_tvalid rises once the accepted sample has passed the product and
// output registers; one item per cycle is taken as long as the output side
// keeps up.
// The error history and skip counter advance in the product stage and the
// accumulator in the sum stage, so back-to-back samples see current state.
// Reset clears all state, config and valid flags. A stall on m_axis_tready
// freezes the whole pipeline and drops s_axis_tready in the same cycle.
// ----------------------------------------------------------------------------
module incremental_pid_controller #(
  parameter int GAIN_WIDTH = ipid_pkg::DEF_GAIN_WIDTH,
  parameter int OUT_WIDTH  = ipid_pkg::DEF_OUT_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [((GAIN_WIDTH > ipid_pkg::LIMIT_W) ?
                 GAIN_WIDTH : ipid_pkg::LIMIT_W)-1:0] cfg_data_i,
  // input samples
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [2*ipid_pkg::IN_W-1:0]           s_axis_tdata,  // measured, target
  // results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((OUT_WIDTH+7)/8)*8-1:0]        m_axis_tdata,  // drive, zero pad
  output logic                                  m_axis_tuser   // updated
);
  import ipid_pkg::*;

  localparam int OUT_DATA_W = ((OUT_WIDTH + 7) / 8) * 8;
  localparam int PP_W       = GAIN_WIDTH + DIFF1_W;
  localparam int PI_W       = GAIN_WIDTH + ERR_W;
  localparam int PD_W       = GAIN_WIDTH + DIFF2_W;
  localparam int SUM_A      = (OUT_WIDTH > PD_W) ? OUT_WIDTH : PD_W;
  localparam int SUM_W      = ((SUM_A > LIMIT_W) ? SUM_A : LIMIT_W) + 2;
  localparam logic [SUM_W-1:0] OUT_MAX =
    {{(SUM_W-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};

  // config registers
  logic signed [GAIN_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0]           out_limit_q;
  logic [SHIFT_W-1:0]           int_shift_q;
  logic [DECIM_W-1:0]           decim_rld_q;
  logic                         zero_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      out_limit_q  <= '0;
      int_shift_q  <= '0;
      decim_rld_q  <= '0;
      zero_clear_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:     gain_p_q     <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_GAIN_I:     gain_i_q     <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_GAIN_D:     gain_d_q     <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_OUT_LIMIT:  out_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_INT_SHIFT:  int_shift_q  <= cfg_data_i[SHIFT_W-1:0];
        CFG_DECIM_RLD:  decim_rld_q  <= cfg_data_i[DECIM_W-1:0];
        CFG_ZERO_CLEAR: zero_clear_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline advance: every stage moves together
  logic pipe_en;
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // stage 0: input register
  logic                   s0_valid_q;
  logic signed [IN_W-1:0] s0_meas_q, s0_tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && s_axis_tvalid) begin
      s0_meas_q <= s_axis_tdata[IN_W-1:0];
      s0_tgt_q  <= s_axis_tdata[2*IN_W-1:IN_W];
    end
  end

  // stage A: error terms, products, history and decimation state
  logic signed [ERR_W-1:0]   err1_q, err2_q, err_a, ishift_a;
  logic signed [DIFF1_W-1:0] diff1_a;
  logic signed [DIFF2_W-1:0] diff2_a;
  logic signed [PP_W-1:0]    prod_p_a;
  logic signed [PI_W-1:0]    prod_i_a;
  logic signed [PD_W-1:0]    prod_d_a;
  logic [DECIM_W-1:0]        skip_q, skip_d;
  logic signed [ERR_W-1:0]   err1_d, err2_d;
  op_e                       op_a;

  always_comb begin
    err_a    = ERR_W'(s0_tgt_q) - ERR_W'(s0_meas_q);
    diff1_a  = DIFF1_W'(err_a) - DIFF1_W'(err1_q);
    diff2_a  = DIFF2_W'(err_a) - (DIFF2_W'(err1_q) <<< 1) + DIFF2_W'(err2_q);
    ishift_a = err_a >>> int_shift_q;
    prod_p_a = gain_p_q * diff1_a;
    prod_i_a = gain_i_q * ishift_a;
    prod_d_a = gain_d_q * diff2_a;

    op_a   = OP_UPDATE;
    skip_d = skip_q;
    err1_d = err1_q;
    err2_d = err2_q;
    if (zero_clear_q && (s0_tgt_q == '0)) begin
      op_a   = OP_CLEAR;
      err1_d = '0;
      err2_d = '0;
    end else if (skip_q != '0) begin
      op_a   = OP_HOLD;
      skip_d = skip_q - DECIM_W'(1);
    end else begin
      skip_d = decim_rld_q;
      err1_d = err_a;
      err2_d = err1_q;
    end
  end

  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic signed [PP_W-1:0] s1_prod_p_q;
  logic signed [PI_W-1:0] s1_prod_i_q;
  logic signed [PD_W-1:0] s1_prod_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_HOLD;
      err1_q     <= '0;
      err2_q     <= '0;
      skip_q     <= '0;
    end else if (pipe_en) begin
      s1_valid_q <= s0_valid_q;
      if (s0_valid_q) begin
        s1_op_q <= op_a;
        err1_q  <= err1_d;
        err2_q  <= err2_d;
        skip_q  <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && s0_valid_q) begin
      s1_prod_p_q <= prod_p_a;
      s1_prod_i_q <= prod_i_a;
      s1_prod_d_q <= prod_d_a;
    end
  end

  // stage B: accumulate and clamp
  logic signed [OUT_WIDTH-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0]     sum_b, lim_b, clamp_b;
  logic [SUM_W-1:0]            lim_raw_b;
  logic                        upd_d;

  always_comb begin
    sum_b     = SUM_W'(acc_q) + SUM_W'(s1_prod_p_q) + SUM_W'(s1_prod_i_q)
              + SUM_W'(s1_prod_d_q);
    lim_raw_b = SUM_W'(out_limit_q);
    lim_b     = (lim_raw_b > OUT_MAX) ? $signed(OUT_MAX) : $signed(lim_raw_b);
    if (sum_b > lim_b) begin
      clamp_b = lim_b;
    end else if (sum_b < -lim_b) begin
      clamp_b = -lim_b;
    end else begin
      clamp_b = sum_b;
    end

    acc_d = acc_q;
    upd_d = 1'b0;
    case (s1_op_q)
      OP_CLEAR:  acc_d = '0;
      OP_UPDATE: begin
        acc_d = clamp_b[OUT_WIDTH-1:0];
        upd_d = 1'b1;
      end
      OP_HOLD:   acc_d = acc_q;
      default:   acc_d = acc_q;
    endcase
  end

  logic signed [OUT_WIDTH-1:0] drive_q;
  logic                        upd_q;
  logic                        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (pipe_en) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && s1_valid_q) begin
      drive_q <= acc_d;
      upd_q   <= upd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'($unsigned(drive_q));
  assign m_axis_tuser  = upd_q;

  // checks
  a_drive_tracks_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q == acc_q))
    else $error("output drive differs from accumulator");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && s0_valid_q && (op_a == OP_UPDATE)) |=> (err2_q == $past(err1_q)))
    else $error("error history did not shift on update");

  a_clear_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && s0_valid_q && (op_a == OP_CLEAR)) |=> ((err1_q == '0) && (err2_q == '0)))
    else $error("error history not cleared");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the incremental PID controller. A class keeps its
// own copy of gains, error history, accumulator and skip counter, predicts
// drive and updated for every accepted sample, and compares each result
// item in order. A directed part covers input extremes, saturation, the
// integral shift on negative errors, decimation and the zero-target clear.
// Random phases then rewrite every register and stream random samples.
// Both sides idle at random, and one phase holds off the output for a long
// stretch so the pipeline fills up.
// ----------------------------------------------------------------------------
module testbench;
  import ipid_pkg::*;

  typedef struct {
    logic signed [31:0] drive;
    logic               updated;
  } drive_result_t;

  class drive_predictor;
    logic signed [15:0] gain_p, gain_i, gain_d;
    logic [30:0]        out_limit;
    logic [3:0]         integral_shift;
    logic [7:0]         decimate_reload;
    logic               zero_set_clear;
    logic signed [16:0] err_prev, err_prev2;
    logic signed [31:0] accum;
    logic [7:0]         skip_count;
    drive_result_t      expected_drive_q[$];
    int                 mismatches;

    function new();
      gain_p = '0; gain_i = '0; gain_d = '0;
      out_limit = '0; integral_shift = '0; decimate_reload = '0;
      zero_set_clear = 1'b0;
      err_prev = '0; err_prev2 = '0; accum = '0; skip_count = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [30:0] value);
      case (idx)
        CFG_GAIN_P:     gain_p = value[15:0];
        CFG_GAIN_I:     gain_i = value[15:0];
        CFG_GAIN_D:     gain_d = value[15:0];
        CFG_OUT_LIMIT:  out_limit = value;
        CFG_INT_SHIFT:  integral_shift = value[3:0];
        CFG_DECIM_RLD:  decimate_reload = value[7:0];
        CFG_ZERO_CLEAR: zero_set_clear = value[0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] meas, logic signed [15:0] tgt);
      longint        err, sum, lim;
      drive_result_t res;
      res.updated = 1'b0;
      if (zero_set_clear && tgt == 0) begin
        accum = '0;
        err_prev = '0;
        err_prev2 = '0;
      end else if (skip_count != 0) begin
        skip_count = skip_count - 8'd1;
      end else begin
        err = longint'(tgt) - longint'(meas);
        lim = out_limit;
        skip_count = decimate_reload;
        sum = longint'(accum)
            + longint'(gain_p) * (err - longint'(err_prev))
            + longint'(gain_i) * (err >>> integral_shift)
            + longint'(gain_d) * (err - 2 * longint'(err_prev) + longint'(err_prev2));
        if (sum > lim) sum = lim;
        else if (sum < -lim) sum = -lim;
        accum = sum[31:0];
        err_prev2 = err_prev;
        err_prev = err[16:0];
        res.updated = 1'b1;
      end
      res.drive = accum;
      expected_drive_q.push_back(res);
    endfunction

    function void check_drive(logic [31:0] drive, logic updated);
      drive_result_t want;
      if (expected_drive_q.size() == 0) begin
        $error("drive: no item pending, got %0d", $signed(drive));
        mismatches++;
        return;
      end
      want = expected_drive_q.pop_front();
      if (drive !== want.drive) begin
        $error("drive: expected %0d, got %0d", want.drive, $signed(drive));
        mismatches++;
      end
      if (updated !== want.updated) begin
        $error("updated: expected %0b, got %0b", want.updated, updated);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // measured, target
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // drive
  logic        m_axis_tuser;        // updated

  drive_predictor pred = new();
  bit             no_idle = 1'b0;
  int             hold_cycles = 0;

  incremental_pid_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(18, 0);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [30:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred.set_reg(idx, value);
  endtask

  task automatic setup(logic signed [15:0] kp, logic signed [15:0] ki,
                       logic signed [15:0] kd, logic [30:0] lim,
                       logic [3:0] shift, logic [7:0] reload, logic clear);
    write_reg(CFG_GAIN_P, {15'd0, kp});
    write_reg(CFG_GAIN_I, {15'd0, ki});
    write_reg(CFG_GAIN_D, {15'd0, kd});
    write_reg(CFG_OUT_LIMIT, lim);
    write_reg(CFG_INT_SHIFT, {27'd0, shift});
    write_reg(CFG_DECIM_RLD, {23'd0, reload});
    write_reg(CFG_ZERO_CLEAR, {30'd0, clear});
  endtask

  task automatic send_sample(logic signed [15:0] meas, logic signed [15:0] tgt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tgt, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    pred.note_sample(meas, tgt);
  endtask

  // called in the step of the last acceptance
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pred.expected_drive_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(64, 0)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($signed($urandom_range(128, 0)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    logic [30:0] lim;
    logic [7:0]  reload;
    case ($urandom_range(7, 0))
      0: lim = '0;
      1, 2: lim = 31'h7FFF_FFFF;
      3, 4: lim = 31'($urandom_range(5000, 1));
      default: lim = 31'($urandom);
    endcase
    case ($urandom_range(7, 0))
      0: reload = 8'hFF;
      1: reload = 8'($urandom);
      default: reload = 8'($urandom_range(3, 0));
    endcase
    setup(pick_gain(), pick_gain(), pick_gain(), lim,
          4'($urandom_range(15, 0)), reload, 1'($urandom));
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      pred.check_drive(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin : stimulus
    logic signed [15:0] tgt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation at both ends, full-scale errors
    setup(16'sh7FFF, -16'sd32768, 16'sh7FFF, 31'h7FFF_FFFF, 4'd0, 8'd0, 1'b0);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd1);
    drain_results();

    // decimation by 3, clear while counting down, max shift on negative error
    setup(-16'sd32768, 16'sd32767, -16'sd32768, 31'd1000, 4'd15, 8'd2, 1'b1);
    send_sample(16'sd5, -16'sd7);
    send_sample(16'sd3, 16'sd4);
    send_sample(16'sd100, 16'sd0);
    send_sample(16'sd1, 16'sd2);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd0);
    drain_results();

    // zero limit, zero target without clear mode
    setup(16'sd3, 16'sd5, -16'sd2, 31'd0, 4'd4, 8'd0, 1'b0);
    send_sample(-16'sd17, 16'sd0);
    send_sample(16'sd20, -16'sd3);
    drain_results();

    setup(16'sd100, 16'sd7, -16'sd50, 31'd20000, 4'd4, 8'd1, 1'b1);
    send_sample(-16'sd17, 16'sd3);
    send_sample(16'sd40, 16'sd3);
    send_sample(16'sd9, -16'sd9);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd5, -16'sd5);
    drain_results();

    for (int phase = 0; phase < 8; phase++) begin
      random_setup();
      no_idle = (phase == 2) || ($urandom_range(3, 0) == 0);
      if (phase == 2) hold_cycles = 300;
      for (int n = 0; n < 88; n++) begin
        tgt = ($urandom_range(7, 0) == 0) ? 16'sd0 : pick_value();
        send_sample(pick_value(), tgt);
      end
      drain_results();
    end

    repeat (10) @(posedge clk_i);
    if (pred.mismatches == 0 && pred.expected_drive_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
